>>> rtl/dsrm_pkg.sv
// ----------------------------------------------------------------------------
// dsrm_pkg
// Shared types and constants of the diagonal similarity run matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package dsrm_pkg;

  localparam int SIM_W   = 16;
  localparam int IDX_W   = 8;
  localparam int LEN_W   = 9;
  localparam int SUM_W   = 23;
  localparam int SCORE_W = 15;
  localparam int LIC_W   = 16;
  localparam int CNT_W   = 5;

  localparam logic [LEN_W-1:0]   LEN_MAX = 9'd511;
  localparam logic [SUM_W-1:0]   SUM_MAX = 23'h7FFFFF;
  localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 15'd8847;

  // configuration register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [SUM_W-1:0] sum;
  } run_entry_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_status_t;

endpackage

`default_nettype wire

>>> rtl/dsrm_run_store.sv
// ----------------------------------------------------------------------------
// dsrm_run_store
// Run store: one length and running sum per slot, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrm_run_store
  import dsrm_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire run_entry_t        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output run_entry_t             rd_data
);

  run_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/dsrm_divider.sv
// ----------------------------------------------------------------------------
// dsrm_divider
// Restoring divider, one quotient bit per cycle, for the run mean.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrm_divider
  import dsrm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire div_req_t req,
  output div_status_t  status
);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [LEN_W-1:0] rem;
  logic [SUM_W-1:0] quo;
  logic             done;
  logic [LEN_W:0]   shifted;
  logic             ge;

  assign shifted = {rem, quo[SUM_W-1]};
  assign ge      = shifted >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(SUM_W - 1);
        rem   <= '0;
        quo   <= req.dividend;
      end else if (busy) begin
        rem   <= ge ? LEN_W'(shifted - {1'b0, req.divisor}) : shifted[LEN_W-1:0];
        quo   <= {quo[SUM_W-2:0], ge};
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.done     = done;
  assign status.quotient = quo;

endmodule

`default_nettype wire

>>> rtl/diagonal_similarity_run_matcher_core.sv
// ----------------------------------------------------------------------------
// diagonal_similarity_run_matcher_core
// Longest above-threshold diagonal run of a similarity matrix, with mean
// score and best-license tracking.
// ----------------------------------------------------------------------------
// Cells arrive row-major on the slave stream. An ordinary cell first reads
// the column's run entry from the run store, then extends or ends the run
// and writes it back; tready is high only while the block waits for a cell.
// A cell with tlast set also runs the bit-serial divider for the mean,
// 23 steps, if a run was found; the next cell is taken only once the
// result is in the output register. The result waits there, so the next
// matrix can start while it is still pending. Run store entries never
// written since reset read as undefined.
`default_nettype none

module diagonal_similarity_run_matcher_core
  import dsrm_pkg::*;
#(
  parameter int MAX_SENTENCES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // similarity [15:0], row_index [23:16], col_index [31:24]
  input  wire logic [31:0]           s_axis_tdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic                  s_axis_tlast,
  // first_license
  input  wire logic                  s_axis_tuser,
  // match_length [8:0], match_end_row [16:9], match_end_col [24:17],
  // mean_score [39:25], best_license [55:40], lead_score [70:56]
  output logic [71:0]                m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // no_match
  output logic                       m_axis_tuser,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int SLOT_W = (MAX_SENTENCES > 1) ? $clog2(MAX_SENTENCES) : 1;
  localparam int NUM_COLS = 1 << IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_START,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [SCORE_W-1:0] threshold;
  logic               cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[CFG_ADDR_W-1:2] == REG_THRESHOLD;
  assign prdata  = cfg_sel ? CFG_DATA_W'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      threshold <= pwdata[SCORE_W-1:0];
    end
  end

  // column to store slot
  logic [SLOT_W-1:0] slot_tab [NUM_COLS];

  for (genvar g = 0; g < NUM_COLS; g++) begin : g_slot
    assign slot_tab[g] = SLOT_W'(g % MAX_SENTENCES);
  end

  logic in_accept;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state == S_IDLE;

  // cell registers
  logic [SIM_W-1:0]  cell_sim;
  logic [IDX_W-1:0]  cell_row;
  logic [IDX_W-1:0]  cell_col;
  logic [SLOT_W-1:0] cell_slot;
  logic              cell_last;
  logic              cell_first;

  // run state
  run_entry_t        held;
  run_entry_t        rd_entry;
  run_entry_t        new_entry;
  logic [LEN_W-1:0]  longest_len;
  logic [SUM_W-1:0]  longest_sum;
  logic [IDX_W-1:0]  longest_row;
  logic [IDX_W-1:0]  longest_col;
  logic [LIC_W-1:0]  license_counter;
  logic [SCORE_W-1:0] lead_score;
  logic [LIC_W-1:0]  lead_license;

  dsrm_run_store #(
    .DEPTH  (MAX_SENTENCES),
    .ADDR_W (SLOT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (state == S_UPD),
    .wr_addr (cell_slot),
    .wr_data (new_entry),
    .rd_en   (in_accept),
    .rd_addr (slot_tab[s_axis_tdata[31:24]]),
    .rd_data (rd_entry)
  );

  // run extension
  logic signed [SIM_W:0] sim_ext;
  logic signed [SIM_W:0] thr_ext;
  logic                  passes;
  logic [SUM_W:0]        sum_add;

  assign sim_ext = {cell_sim[SIM_W-1], cell_sim};
  assign thr_ext = {2'b00, threshold};
  assign passes  = sim_ext > thr_ext;
  assign sum_add = {1'b0, held.sum} + (SUM_W + 1)'(cell_sim[SCORE_W-1:0]);

  always_comb begin
    new_entry = '0;
    if (passes) begin
      if (cell_row == '0 || cell_col == '0) begin
        new_entry.len = LEN_W'(1);
        new_entry.sum = SUM_W'(cell_sim[SCORE_W-1:0]);
      end else begin
        new_entry.len = (held.len == LEN_MAX) ? LEN_MAX : held.len + 1'b1;
        new_entry.sum = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      end
    end
  end

  // mean division
  div_req_t    div_req;
  div_status_t div_st;

  assign div_req.start    = (state == S_START) && (longest_len != '0);
  assign div_req.dividend = longest_sum;
  assign div_req.divisor  = longest_len;

  dsrm_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .status (div_st)
  );

  logic [SCORE_W-1:0] mean;
  logic               better;

  assign mean   = div_st.quotient[SCORE_W-1:0];
  assign better = mean > lead_score;

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_axis_tvalid   <= 1'b0;
      held            <= '0;
      longest_len     <= '0;
      longest_sum     <= '0;
      longest_row     <= '0;
      longest_col     <= '0;
      license_counter <= '0;
      lead_score      <= '0;
      lead_license    <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            cell_sim   <= s_axis_tdata[15:0];
            cell_row   <= s_axis_tdata[23:16];
            cell_col   <= s_axis_tdata[31:24];
            cell_slot  <= slot_tab[s_axis_tdata[31:24]];
            cell_last  <= s_axis_tlast;
            cell_first <= s_axis_tuser;
            state      <= S_UPD;
          end
        end
        S_UPD: begin
          if (cell_first) begin
            lead_score      <= '0;
            lead_license    <= '0;
            license_counter <= '0;
          end
          held <= rd_entry;
          if (new_entry.len > longest_len) begin
            longest_len <= new_entry.len;
            longest_sum <= new_entry.sum;
            longest_row <= cell_row;
            longest_col <= cell_col;
          end
          state <= cell_last ? S_START : S_IDLE;
        end
        S_START: begin
          state <= (longest_len == '0) ? S_EMIT : S_WAIT;
        end
        S_WAIT: begin
          if (div_st.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            if (longest_len == '0) begin
              m_axis_tuser <= 1'b1;
              m_axis_tdata <= {1'b0, lead_score, lead_license, 40'd0};
            end else begin
              m_axis_tuser <= 1'b0;
              if (better) begin
                lead_score   <= mean;
                lead_license <= license_counter;
                m_axis_tdata <= {1'b0, mean, license_counter, mean,
                                 longest_col, longest_row, longest_len};
              end else begin
                m_axis_tdata <= {1'b0, lead_score, lead_license, mean,
                                 longest_col, longest_row, longest_len};
              end
            end
            license_counter <= license_counter + 1'b1;
            longest_len     <= '0;
            longest_sum     <= '0;
            longest_row     <= '0;
            longest_col     <= '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(state == S_EMIT))
    else $error("result appeared outside the emit step");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_WAIT)
    else $error("divider finished while not awaited");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[39:0] == 40'd0))
    else $error("no-match result carries a run");

  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    (lead_score < $past(lead_score)) |-> $past(state == S_UPD && cell_first))
    else $error("best score dropped without a first-license request");

endmodule

`default_nettype wire
